// ===== rtl/cps_pkg.sv =====
// Shared widths, codes and word types for the closest-point-on-segment block.
// No dependencies; every other file in rtl/ imports this package.
package cps_pkg;

    // Coordinate width; every other width below follows from it.
    localparam int COORD_W = 16;
    // Difference of two coordinates.
    localparam int DIFF_W  = COORD_W + 1;
    // Signed product of two differences.
    localparam int PROD_W  = 2 * DIFF_W;
    // Signed dot product (sum of two products).
    localparam int NUM_W   = PROD_W + 1;
    // Squared length |B - A|^2, unsigned.
    localparam int DEN_W   = 2 * COORD_W + 1;
    // Divisor 2 * den and the partial remainder of the divider.
    localparam int DVS_W   = DEN_W + 1;
    // Quotient bits: the offset from A never exceeds |B - A| on its axis.
    localparam int QUO_W   = COORD_W;
    // num * |d| for an interior point.
    localparam int SCL_W   = DEN_W + COORD_W;
    // Dividend 2 * num * |d| + den.
    localparam int DVD_W   = SCL_W + 2;

    // Stream word widths.
    localparam int TDATA_W = ((2 * COORD_W + 7) / 8) * 8;
    localparam int TUSER_W = 2;

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_START_X = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_START_Y = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_END_X   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_END_Y   = 2'd3;

    // Region codes.
    localparam logic [1:0] REGION_INTERIOR = 2'd0;
    localparam logic [1:0] REGION_START    = 2'd1;
    localparam logic [1:0] REGION_END      = 2'd2;
    localparam logic [1:0] REGION_DEGEN    = 2'd3;

    typedef logic signed [COORD_W-1:0] coord_t;

    // Segment endpoints as held in the configuration registers.
    typedef struct packed {
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
    } seg_t;

    // Word handed from cell to cell along the divider chain.
    typedef struct packed {
        logic               valid;
        logic [1:0]         region;
        coord_t             base_x;
        coord_t             base_y;
        logic               sub_x;
        logic               sub_y;
        logic [DVS_W-1:0]   dvs;
        logic [DVS_W-1:0]   rem_x;
        logic [DVS_W-1:0]   rem_y;
        logic [QUO_W-1:0]   low_x;
        logic [QUO_W-1:0]   low_y;
        logic [QUO_W-1:0]   quo_x;
        logic [QUO_W-1:0]   quo_y;
    } cell_word_t;

    // One finished result.
    typedef struct packed {
        coord_t     x;
        coord_t     y;
        logic [1:0] region;
    } result_t;

endpackage

// ===== rtl/cps_setup.sv =====
// Front stages: differences, products, dot product and squared length,
// region decision and the per-axis dividend. Depends on cps_pkg.
module cps_setup (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  cps_pkg::seg_t      seg,
    input  logic               in_valid,
    input  cps_pkg::coord_t    in_x,
    input  cps_pkg::coord_t    in_y,
    output cps_pkg::cell_word_t word_out
);
    import cps_pkg::*;

    // Stage 1: differences.
    logic                     s1_valid_reg;
    logic signed [DIFF_W-1:0] s1_ex_reg, s1_ey_reg, s1_dx_reg, s1_dy_reg;

    // Stage 2: products.
    logic                     s2_valid_reg;
    logic signed [PROD_W-1:0] s2_pex_reg, s2_pey_reg, s2_sdx_reg, s2_sdy_reg;
    logic signed [DIFF_W-1:0] s2_dx_reg, s2_dy_reg;

    // Stage 3: dot product and squared length.
    logic                     s3_valid_reg;
    logic signed [NUM_W-1:0]  s3_num_reg;
    logic [DEN_W-1:0]         s3_den_reg;
    logic signed [DIFF_W-1:0] s3_dx_reg, s3_dy_reg;

    // Stage 4: region and scaled numerators.
    logic                     s4_valid_reg;
    logic [1:0]               s4_region_reg;
    coord_t                   s4_base_x_reg, s4_base_y_reg;
    logic                     s4_sub_x_reg, s4_sub_y_reg;
    logic [DEN_W-1:0]         s4_den_reg;
    logic [SCL_W-1:0]         s4_scl_x_reg, s4_scl_y_reg;

    cell_word_t               word_reg;

    // Stage 4 decision logic.
    logic                     num_neg, num_zero, num_ge, den_zero;
    logic [1:0]               region_next;
    logic signed [DIFF_W-1:0] abs_x, abs_y;
    logic [COORD_W-1:0]       mag_x, mag_y;
    logic [DEN_W-1:0]         num_u;

    // Stage 5 dividend.
    logic [DVD_W-1:0]         dvd_x, dvd_y;
    logic                     interior;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_ex_reg <= DIFF_W'(in_x) - DIFF_W'(seg.ax);
            s1_ey_reg <= DIFF_W'(in_y) - DIFF_W'(seg.ay);
            s1_dx_reg <= DIFF_W'(seg.bx) - DIFF_W'(seg.ax);
            s1_dy_reg <= DIFF_W'(seg.by) - DIFF_W'(seg.ay);

            s2_pex_reg <= s1_ex_reg * s1_dx_reg;
            s2_pey_reg <= s1_ey_reg * s1_dy_reg;
            s2_sdx_reg <= s1_dx_reg * s1_dx_reg;
            s2_sdy_reg <= s1_dy_reg * s1_dy_reg;
            s2_dx_reg  <= s1_dx_reg;
            s2_dy_reg  <= s1_dy_reg;

            s3_num_reg <= NUM_W'(s2_pex_reg) + NUM_W'(s2_pey_reg);
            s3_den_reg <= DEN_W'(s2_sdx_reg[2*COORD_W-1:0])
                        + DEN_W'(s2_sdy_reg[2*COORD_W-1:0]);
            s3_dx_reg  <= s2_dx_reg;
            s3_dy_reg  <= s2_dy_reg;

            s4_region_reg <= region_next;
            s4_base_x_reg <= (region_next == REGION_END) ? seg.bx : seg.ax;
            s4_base_y_reg <= (region_next == REGION_END) ? seg.by : seg.ay;
            s4_sub_x_reg  <= s3_dx_reg[DIFF_W-1];
            s4_sub_y_reg  <= s3_dy_reg[DIFF_W-1];
            s4_den_reg    <= s3_den_reg;
            s4_scl_x_reg  <= SCL_W'(num_u) * SCL_W'(mag_x);
            s4_scl_y_reg  <= SCL_W'(num_u) * SCL_W'(mag_y);
        end
    end

    // Region decision; the degenerate case wins over every other test.
    always_comb begin
        num_neg  = s3_num_reg[NUM_W-1];
        num_zero = (s3_num_reg == '0);
        den_zero = (s3_den_reg == '0);
        num_ge   = !num_neg && (s3_num_reg[NUM_W-2:0] >= (NUM_W-1)'(s3_den_reg));
        if (den_zero) begin
            region_next = REGION_DEGEN;
        end else if (num_ge) begin
            region_next = REGION_END;
        end else if (num_neg || num_zero) begin
            region_next = REGION_START;
        end else begin
            region_next = REGION_INTERIOR;
        end
        abs_x = s3_dx_reg[DIFF_W-1] ? -s3_dx_reg : s3_dx_reg;
        abs_y = s3_dy_reg[DIFF_W-1] ? -s3_dy_reg : s3_dy_reg;
        // A zero magnitude makes the quotient zero for clamped points.
        mag_x = (region_next == REGION_INTERIOR) ? abs_x[COORD_W-1:0] : '0;
        mag_y = (region_next == REGION_INTERIOR) ? abs_y[COORD_W-1:0] : '0;
        // For an interior point 0 < num < den, so it fits the den width.
        num_u = s3_num_reg[DEN_W-1:0];
    end

    // Dividend 2*num*|d| + den gives rounding half away from zero after
    // the floor division by 2*den.
    always_comb begin
        interior = (s4_region_reg == REGION_INTERIOR);
        dvd_x    = interior ? (DVD_W'({s4_scl_x_reg, 1'b0}) + DVD_W'(s4_den_reg)) : '0;
        dvd_y    = interior ? (DVD_W'({s4_scl_y_reg, 1'b0}) + DVD_W'(s4_den_reg)) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg <= '0;
        end else if (advance) begin
            word_reg.valid  <= s4_valid_reg;
            word_reg.region <= s4_region_reg;
            word_reg.base_x <= s4_base_x_reg;
            word_reg.base_y <= s4_base_y_reg;
            word_reg.sub_x  <= s4_sub_x_reg;
            word_reg.sub_y  <= s4_sub_y_reg;
            // Clamped points divide zero by the largest divisor.
            word_reg.dvs    <= interior ? {s4_den_reg, 1'b0} : '1;
            word_reg.rem_x  <= dvd_x[QUO_W+DVS_W-1:QUO_W];
            word_reg.rem_y  <= dvd_y[QUO_W+DVS_W-1:QUO_W];
            word_reg.low_x  <= dvd_x[QUO_W-1:0];
            word_reg.low_y  <= dvd_y[QUO_W-1:0];
            word_reg.quo_x  <= '0;
            word_reg.quo_y  <= '0;
        end
    end

    assign word_out = word_reg;

endmodule

// ===== rtl/cps_div_cell.sv =====
// One cell of the divider chain: a restoring step on both axes, one
// quotient bit each. Depends on cps_pkg.
module cps_div_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  cps_pkg::cell_word_t word_in,
    output cps_pkg::cell_word_t word_out
);
    import cps_pkg::*;

    logic [DVS_W:0]   ext_x, ext_y;
    logic [DVS_W+1:0] dif_x, dif_y;
    logic             fit_x, fit_y;
    cell_word_t       word_next, word_reg;

    always_comb begin
        ext_x = {word_in.rem_x, word_in.low_x[QUO_W-1]};
        ext_y = {word_in.rem_y, word_in.low_y[QUO_W-1]};
        dif_x = {1'b0, ext_x} - {2'b00, word_in.dvs};
        dif_y = {1'b0, ext_y} - {2'b00, word_in.dvs};
        fit_x = !dif_x[DVS_W+1];
        fit_y = !dif_y[DVS_W+1];

        word_next       = word_in;
        word_next.rem_x = fit_x ? dif_x[DVS_W-1:0] : ext_x[DVS_W-1:0];
        word_next.rem_y = fit_y ? dif_y[DVS_W-1:0] : ext_y[DVS_W-1:0];
        word_next.low_x = {word_in.low_x[QUO_W-2:0], 1'b0};
        word_next.low_y = {word_in.low_y[QUO_W-2:0], 1'b0};
        word_next.quo_x = {word_in.quo_x[QUO_W-2:0], fit_x};
        word_next.quo_y = {word_in.quo_y[QUO_W-2:0], fit_y};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg <= '0;
        end else if (advance) begin
            word_reg <= word_next;
        end
    end

    assign word_out = word_reg;

endmodule

// ===== rtl/cps_out.sv =====
// Final offset add, output register and skid register. The skid register
// decides when the whole pipeline moves. Depends on cps_pkg.
module cps_out (
    input  logic                aclk,
    input  logic                aresetn,
    input  cps_pkg::cell_word_t word_in,
    output logic                advance,
    output logic                out_valid,
    input  logic                out_ready,
    output cps_pkg::result_t    out_word
);
    import cps_pkg::*;

    result_t res_next, out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;
    logic    take;

    always_comb begin
        res_next.x      = word_in.sub_x ? (word_in.base_x - coord_t'(word_in.quo_x))
                                        : (word_in.base_x + coord_t'(word_in.quo_x));
        res_next.y      = word_in.sub_y ? (word_in.base_y - coord_t'(word_in.quo_y))
                                        : (word_in.base_y + coord_t'(word_in.quo_y));
        res_next.region = word_in.region;
        take            = advance && word_in.valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_reg        <= skid_reg;
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_reg        <= res_next;
                out_valid_reg  <= take;
            end
        end else if (take) begin
            skid_reg       <= res_next;
            skid_valid_reg <= 1'b1;
        end
    end

    assign advance   = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule

// ===== rtl/closest_point_on_segment.sv =====
// Top level of the closest-point-on-segment block: configuration registers,
// setup stages, divider cell chain and output stage. Depends on cps_pkg,
// cps_setup, cps_div_cell and cps_out.
//
//   Channel   Direction  Handshake                   Payload
//   s_axis    in         s_axis_tvalid/s_axis_tready  point_x, point_y
//   m_axis    out        m_axis_tvalid/m_axis_tready  closest_x, closest_y; region
//   cfg       in         cfg_we (no wait)             start_x, start_y, end_x, end_y
//
// One word enters per cycle and one result leaves per cycle while the output
// is not stalled. A word passes 22 registers: five setup stages, one cell per
// quotient bit (16 cells), and the output register. The first is loaded at
// the accepting edge.
// Reset is synchronous and active low; it clears the endpoints to zero and
// empties the pipeline.
// When the output is stalled, one result parks in a skid register and the
// whole pipeline then holds; s_axis_tready is a register output and does
// not depend on m_axis_tready in the same cycle.
module closest_point_on_segment (
    input  logic                                aclk,
    input  logic                                aresetn,

    // Input words.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata, lowest bit up: point_x, point_y.
    input  logic [cps_pkg::TDATA_W-1:0]         s_axis_tdata,

    // Result words.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata, lowest bit up: closest_x, closest_y.
    output logic [cps_pkg::TDATA_W-1:0]         m_axis_tdata,
    // tuser: region (interior, clamped to start, clamped to end, degenerate).
    output logic [cps_pkg::TUSER_W-1:0]         m_axis_tuser,

    // Configuration writes.
    input  logic                                cfg_we,
    input  logic [cps_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [cps_pkg::COORD_W-1:0]         cfg_wdata
);
    import cps_pkg::*;

    seg_t       seg_reg;
    logic       advance;
    coord_t     in_x, in_y;
    cell_word_t chain [QUO_W+1];
    result_t    out_word;

    // Endpoint registers. The user must write them only while the pipeline is empty
    // (the block itself does not enforce this), so every stage may read them directly.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_START_X: seg_reg.ax <= cfg_wdata;
                REG_START_Y: seg_reg.ay <= cfg_wdata;
                REG_END_X:   seg_reg.bx <= cfg_wdata;
                REG_END_Y:   seg_reg.by <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Unpack the query point from the input word.
    assign in_x          = s_axis_tdata[COORD_W-1:0];
    assign in_y          = s_axis_tdata[2*COORD_W-1:COORD_W];
    assign s_axis_tready = advance;

    // Differences, products, region decision and dividend.
    cps_setup u_setup (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .seg      (seg_reg),
        .in_valid (s_axis_tvalid),
        .in_x     (in_x),
        .in_y     (in_y),
        .word_out (chain[0])
    );

    // Divider chain: each cell settles one quotient bit for both axes,
    // most significant bit first.
    for (genvar i = 0; i < QUO_W; i++) begin : g_cell
        cps_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .word_in  (chain[i]),
            .word_out (chain[i+1])
        );
    end

    // Apply the offset to the base point and hand the result out.
    cps_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .word_in   (chain[QUO_W]),
        .advance   (advance),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (out_word)
    );

    // Pack the result word; unused high bits stay zero.
    always_comb begin
        m_axis_tdata                      = '0;
        m_axis_tdata[COORD_W-1:0]         = out_word.x;
        m_axis_tdata[2*COORD_W-1:COORD_W] = out_word.y;
        m_axis_tuser                      = out_word.region;
    end

endmodule
